// File: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, status codes and types of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MEM_BYTES_DEF = 65536;
    localparam int HEADER_BYTES  = 16;
    localparam int MIN_BLOCK     = 32;
    localparam int MIN_ORD       = 5;     // log2 of MIN_BLOCK
    localparam int MIN_REGION    = 6;     // smallest region log2
    localparam int ENTRY_W       = 7;
    localparam int ORD_W         = 5;
    localparam logic [4:0] SIZE_LOG2_RST = 5'd16;

    // entry layout: head, free, order
    localparam int HEAD_POS = 6;
    localparam int FREE_POS = 5;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_BADREL = 2'd2;

    // operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic [15:0] payload_address;
        logic [16:0] granted_bytes;
        logic [1:0]  status;
    } result_t;

endpackage

// File: hw/rtl/buddy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator with its block table in one on-chip RAM.
// ----------------------------------------------------------------------------
// One item is handled at a time against a table with one 7-bit entry per
// 32-byte unit, held in a RAM with a registered read. An allocate reads and
// checks the entry of each block visited on the lowest-address search, then
// splits the found block down step by step, marks the grant and delivers the
// result. A release reads and checks its entry, reads and checks the buddy at
// each merge level, writes the freed block and delivers. A release address
// rejected on sight goes straight to delivery. The next item is taken in the
// idle state after delivery, so a full-region search dominates the worst
// case. After reset and after every write of the region size register the
// table is rebuilt by a clearing pass over all MEM_BYTES/32 entries (2048
// by default) during which no item is accepted. A finished result waits
// in the output register and the next item may be accepted meanwhile;
// while that register is still full, the unit holds in its delivery state.
module buddy_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [15:0] request_bytes,
    input  logic [15:0] release_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] payload_address,
    output logic [16:0] granted_bytes,
    output logic [1:0]  status
);

    localparam logic [4:0] TOP_LG = 5'($clog2(MEM_BYTES));

    logic [4:0] size_log2_reg;
    logic [4:0] lg_eff;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       res_valid;
    result_t    res;
    logic       out_free;

    // region size register and clamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= SIZE_LOG2_RST;
        end
        else if (cfg_we)
        begin
            size_log2_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        lg_eff = size_log2_reg;
        if (lg_eff < 5'(MIN_REGION))
        begin
            lg_eff = 5'(MIN_REGION);
        end
        if (lg_eff > TOP_LG)
        begin
            lg_eff = TOP_LG;
        end
    end

    bba_engine #(.MEM_BYTES(MEM_BYTES)) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .restart         (cfg_we),
        .lg              (lg_eff),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .request_bytes   (request_bytes),
        .release_address (release_address),
        .out_free        (out_free),
        .res_valid       (res_valid),
        .res             (res)
    );

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign payload_address = out_reg.payload_address;
    assign granted_bytes   = out_reg.granted_bytes;
    assign status          = out_reg.status;

endmodule

// File: hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/bba_engine.sv
// ----------------------------------------------------------------------------
// bba_engine
// Block table walker: clearing pass, allocate search and split, release merge.
// ----------------------------------------------------------------------------
module bba_engine
    import bba_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        restart,     // region size written: rebuild table
    input  logic [4:0]  lg,          // clamped region log2
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [15:0] request_bytes,
    input  logic [15:0] release_address,
    input  logic        out_free,
    output logic        res_valid,
    output result_t     res
);

    localparam int LGW   = $clog2(MEM_BYTES);
    localparam int UNITS = MEM_BYTES / MIN_BLOCK;
    localparam int UW    = LGW - MIN_ORD;
    localparam int OW    = ((LGW > 16) ? LGW : 16) + 1;
    localparam int SW    = OW + 1;

    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_ARD  = 10'b0000000100,
        S_ACHK = 10'b0000001000,
        S_ASPL = 10'b0000010000,
        S_RRD  = 10'b0000100000,
        S_RCHK = 10'b0001000000,
        S_BRD  = 10'b0010000000,
        S_BCHK = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [OW-1:0]   off_reg, off_next;
    logic [ORD_W-1:0] ord_reg, ord_next;
    logic [16:0]     need_reg, need_next;
    logic [UW-1:0]   cnt_reg, cnt_next;
    result_t         res_reg, res_next;

    logic              ram_we, ram_re;
    logic [UW-1:0]     ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    bba_ram #(.WIDTH(ENTRY_W), .DEPTH(UNITS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // derived values
    logic [SW-1:0]    region, size_reg, half_reg, size_e, off_plus, bud_w;
    logic [OW-1:0]    split_off, bud, rel_off;
    logic [15:0]      rel_off16;
    logic [ORD_W-1:0] e_ord;
    logic [UW-1:0]    unit;
    logic [ENTRY_W-1:0] free_entry;

    assign region     = SW'(1) << lg;
    assign size_reg   = SW'(1) << ord_reg;
    assign half_reg   = size_reg >> 1;
    assign e_ord      = ram_rdata[ORD_W-1:0];
    assign size_e     = SW'(1) << e_ord;
    assign off_plus   = SW'(off_reg) + size_e;
    assign split_off  = off_reg + half_reg[OW-1:0];
    assign bud        = off_reg ^ size_reg[OW-1:0];
    assign bud_w      = SW'(bud);
    assign unit       = off_reg[LGW-1:MIN_ORD];
    assign rel_off16  = release_address - 16'(HEADER_BYTES);
    assign rel_off    = OW'(rel_off16);
    assign free_entry = {1'b1, 1'b1, ord_reg};

    assign in_ready  = (state_reg == S_IDLE);
    assign res       = res_reg;
    assign res_valid = (state_reg == S_FIN) && out_free;

    // next-state and table access
    always_comb
    begin
        state_next = state_reg;
        off_next   = off_reg;
        ord_next   = ord_reg;
        need_next  = need_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = unit;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = unit;

        case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = (cnt_reg == '0) ? {1'b1, 1'b1, lg} : '0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == {UW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_ALLOC)
                    begin
                        off_next   = '0;
                        need_next  = {1'b0, request_bytes} + 17'(HEADER_BYTES);
                        state_next = S_ARD;
                    end
                    else if (release_address < 16'(HEADER_BYTES) ||
                             rel_off16[MIN_ORD-1:0] != '0 ||
                             SW'(rel_off) >= region)
                    begin
                        res_next   = '{16'd0, 17'd0, ST_BADREL};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        off_next   = rel_off;
                        state_next = S_RRD;
                    end
                end
            end
            S_ARD:
            begin
                ram_re     = 1'b1;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (!ram_rdata[HEAD_POS] || e_ord < ORD_W'(MIN_ORD))
                begin
                    res_next   = '{16'd0, 17'd0, ST_NOFIT};
                    state_next = S_FIN;
                end
                else if (ram_rdata[FREE_POS] && size_e >= SW'(need_reg))
                begin
                    ord_next   = e_ord;
                    state_next = S_ASPL;
                end
                else if (off_plus >= region)
                begin
                    res_next   = '{16'd0, 17'd0, ST_NOFIT};
                    state_next = S_FIN;
                end
                else
                begin
                    off_next   = off_plus[OW-1:0];
                    state_next = S_ARD;
                end
            end
            S_ASPL:
            begin
                ram_we = 1'b1;
                if (ord_reg > ORD_W'(MIN_ORD) && half_reg > SW'(need_reg))
                begin
                    // upper half becomes a free block
                    ram_waddr = split_off[LGW-1:MIN_ORD];
                    ram_wdata = {1'b1, 1'b1, ord_reg - 1'b1};
                    ord_next  = ord_reg - 1'b1;
                end
                else
                begin
                    ram_wdata  = {1'b1, 1'b0, ord_reg};
                    res_next   = '{off_reg[15:0] + 16'(HEADER_BYTES),
                                   size_reg[16:0], ST_OK};
                    state_next = S_FIN;
                end
            end
            S_RRD:
            begin
                ram_re     = 1'b1;
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                if (!ram_rdata[HEAD_POS] || ram_rdata[FREE_POS])
                begin
                    res_next   = '{16'd0, 17'd0, ST_BADREL};
                    state_next = S_FIN;
                end
                else
                begin
                    ord_next   = e_ord;
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                if (ord_reg < lg && bud_w < region)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = bud[LGW-1:MIN_ORD];
                    state_next = S_BCHK;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = free_entry;
                    res_next   = '{16'd0, 17'd0, ST_OK};
                    state_next = S_FIN;
                end
            end
            S_BCHK:
            begin
                ram_we = 1'b1;
                if (ram_rdata != free_entry)
                begin
                    ram_wdata  = free_entry;
                    res_next   = '{16'd0, 17'd0, ST_OK};
                    state_next = S_FIN;
                end
                else
                begin
                    // merge: the upper of the pair loses its head
                    if (bud < off_reg)
                    begin
                        off_next = bud;
                    end
                    else
                    begin
                        ram_waddr = bud[LGW-1:MIN_ORD];
                    end
                    ram_wdata  = '0;
                    ord_next   = ord_reg + 1'b1;
                    state_next = S_BRD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase

        if (restart)
        begin
            state_next = S_CLR;
            cnt_next   = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        ord_reg  <= ord_next;
        need_reg <= need_next;
        res_reg  <= res_next;
    end

endmodule

// File: hw/rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level assertions for the buddy block allocator, bound to the top.
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] payload_address,
    input logic [16:0] granted_bytes,
    input logic [1:0]  status
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_address)
                                    && $stable(status))
        else $error("stalled result changed");

    // only defined status codes
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_NOFIT || status == ST_BADREL))
        else $error("undefined status");

    // failures carry no grant
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> payload_address == 16'd0 && granted_bytes == 17'd0)
        else $error("grant on failure");

    // a grant is a power-of-two block, header past a unit boundary
    a_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted_bytes != 17'd0 |->
            $onehot(granted_bytes) && granted_bytes >= 17'(MIN_BLOCK)
            && payload_address[4:0] == 5'(HEADER_BYTES))
        else $error("malformed grant");

    // table rebuild blocks intake
    a_clr: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("item taken during rebuild");

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .payload_address (payload_address),
    .granted_bytes   (granted_bytes),
    .status          (status)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buddy block allocator: a behavioral allocator
// predicts every result, random traffic with idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_top
    import bba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS = MEM_BYTES_DEF / MIN_BLOCK;
    localparam int LIMIT = 25000000;

    // Allocator state mirror and expected result queue
    class alloc_scoreboard;
        logic [6:0]  blocks[UNITS];
        logic [4:0]  size_reg;
        result_t     pending[$];
        int          errors;

        function int region_lg();
            int lg;
            lg = size_reg;
            if (lg < MIN_REGION) lg = MIN_REGION;
            if (lg > 16) lg = 16;
            return lg;
        endfunction

        function void set_size(logic [4:0] v);
            size_reg = v;
            foreach (blocks[i]) blocks[i] = '0;
            blocks[0] = {1'b1, 1'b1, 5'(region_lg())};
        endfunction

        function result_t allocate(int req);
            result_t r;
            int region, need, off, ord, sz;
            logic [6:0] e;
            region = 1 << region_lg();
            need = req + HEADER_BYTES;
            off = 0;
            r = '0;
            r.status = ST_NOFIT;
            while (off < region) begin
                e = blocks[off / MIN_BLOCK];
                ord = e[4:0];
                sz = 1 << ord;
                if (!e[HEAD_POS] || sz < MIN_BLOCK) break;
                if (e[FREE_POS] && sz >= need) begin
                    while (sz / 2 > need && sz / 2 >= MIN_BLOCK) begin
                        ord--;
                        sz = sz / 2;
                        blocks[(off + sz) / MIN_BLOCK] = {1'b1, 1'b1, 5'(ord)};
                    end
                    blocks[off / MIN_BLOCK] = {1'b1, 1'b0, 5'(ord)};
                    r.payload_address = 16'(off + HEADER_BYTES);
                    r.granted_bytes = 17'(sz);
                    r.status = ST_OK;
                    return r;
                end
                off += sz;
            end
            return r;
        endfunction

        function result_t release_blk(int addr);
            result_t r;
            int lg, region, off, u, ord, bud;
            logic [6:0] e;
            lg = region_lg();
            region = 1 << lg;
            r = '0;
            r.status = ST_BADREL;
            if (addr < HEADER_BYTES) return r;
            off = addr - HEADER_BYTES;
            if (off % MIN_BLOCK != 0 || off >= region) return r;
            u = off / MIN_BLOCK;
            e = blocks[u];
            if (!e[HEAD_POS] || e[FREE_POS]) return r;
            ord = e[4:0];
            // merge upward while the buddy is a free block of equal order
            while (ord < lg) begin
                bud = off ^ (1 << ord);
                if (bud >= region || blocks[bud / MIN_BLOCK] != {1'b1, 1'b1, 5'(ord)})
                    break;
                if (bud < off) begin
                    blocks[u] = '0;
                    off = bud;
                    u = bud / MIN_BLOCK;
                end else begin
                    blocks[bud / MIN_BLOCK] = '0;
                end
                ord++;
            end
            blocks[u] = {1'b1, 1'b1, 5'(ord)};
            r.status = ST_OK;
            return r;
        endfunction

        function void note_item(logic o, logic [15:0] req, logic [15:0] addr);
            if (o == OP_ALLOC) pending.push_back(allocate(req));
            else pending.push_back(release_blk(addr));
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.payload_address !== exp.payload_address) begin
                $display("%0t payload_address exp %0d got %0d", $time,
                         exp.payload_address, got.payload_address);
                errors++;
            end
            if (got.granted_bytes !== exp.granted_bytes) begin
                $display("%0t granted_bytes exp %0d got %0d", $time,
                         exp.granted_bytes, got.granted_bytes);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [15:0] request_bytes;
    logic [15:0] release_address;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] payload_address;
    logic [16:0] granted_bytes;
    logic [1:0]  status;

    alloc_scoreboard sb;
    logic [15:0] live_addrs[$];
    int          cycles;
    bit          long_stall;

    buddy_block_allocator_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .op(op),
        .request_bytes(request_bytes), .release_address(release_address),
        .out_valid(out_valid), .out_ready(out_ready),
        .payload_address(payload_address), .granted_bytes(granted_bytes),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check accepted items, random stalls plus one long hold-off
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (long_stall) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_stall = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 1) == 0) wait_n = 0;
            if (wait_n > 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_result('{payload_address, granted_bytes, status});
        end
    end

    task automatic send_item(logic o, logic [15:0] req, logic [15:0] addr, bit gaps);
        int wait_n;
        wait_n = gaps ? $urandom_range(0, 19) : 0;
        if (gaps && $urandom_range(0, 2) == 0) wait_n = 0;
        if (wait_n > 0) begin
            in_valid <= 1'b0;
            repeat (wait_n) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        request_bytes <= req;
        release_address <= addr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(o, req, addr);
        if (o == OP_ALLOC && sb.pending[$].status == ST_OK)
            live_addrs.push_back(sb.pending[$].payload_address);
    endtask

    task automatic drain_and_write(logic [4:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_size(v);
        live_addrs.delete();
    endtask

    task automatic random_item(int lg, bit gaps);
        int k, idx;
        logic [15:0] req, addr;
        k = $urandom_range(0, 99);
        req = (k < 5) ? 16'($urandom) : 16'($urandom_range(0, (1 << lg) / 2));
        if ($urandom_range(0, 9) == 0) req = 16'($urandom_range(0, 64));
        addr = 16'($urandom);
        if (k < 45 || live_addrs.size() == 0) begin
            send_item(OP_ALLOC, req, addr, gaps);
        end else if (k < 90) begin
            idx = $urandom_range(0, live_addrs.size() - 1);
            addr = live_addrs[idx];
            live_addrs.delete(idx);
            send_item(OP_RELEASE, req, addr, gaps);
        end else begin
            // bogus or repeated release
            if (k < 94) addr = 16'($urandom_range(0, 2048) * 32 + 16);
            send_item(OP_RELEASE, req, addr, gaps);
        end
    endtask

    // Stimulus
    initial
    begin
        logic [4:0] sizes[8];
        int lg;
        sb = new();
        sb.set_size(SIZE_LOG2_RST);
        cycles = 0;
        long_stall = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        op = OP_ALLOC;
        request_bytes = '0;
        release_address = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, whole region grant, bad releases, merging
        send_item(OP_ALLOC, 16'd65520, 16'hFFFF, 0);
        send_item(OP_ALLOC, 16'd65519, 16'h0000, 0);
        send_item(OP_RELEASE, 16'h0, 16'd16, 0);
        send_item(OP_RELEASE, 16'h0, 16'd16, 0);
        send_item(OP_ALLOC, 16'h0, 16'h0, 0);
        send_item(OP_ALLOC, 16'd16, 16'h0, 0);
        send_item(OP_ALLOC, 16'd17, 16'h0, 0);
        send_item(OP_RELEASE, 16'hFFFF, 16'd15, 0);
        send_item(OP_RELEASE, 16'h0, 16'd0, 0);
        send_item(OP_RELEASE, 16'h0, 16'd24, 0);
        send_item(OP_RELEASE, 16'h0, 16'hFFF0, 0);
        send_item(OP_RELEASE, 16'h0, 16'd48, 0);
        send_item(OP_RELEASE, 16'h0, 16'd16, 0);
        send_item(OP_RELEASE, 16'h0, 16'd80, 0);
        send_item(OP_ALLOC, 16'd65520, 16'h0, 0);

        // tiny region, then out-of-range values that clamp
        drain_and_write(5'd6);
        send_item(OP_ALLOC, 16'd48, 16'h0, 0);
        send_item(OP_ALLOC, 16'd0, 16'h0, 0);
        send_item(OP_RELEASE, 16'h0, 16'd16, 0);
        send_item(OP_RELEASE, 16'h0, 16'd80, 0);
        send_item(OP_ALLOC, 16'd16, 16'h0, 0);
        send_item(OP_ALLOC, 16'd16, 16'h0, 0);
        send_item(OP_ALLOC, 16'd0, 16'h0, 0);

        sizes = '{5'd0, 5'd31, 5'd10, 5'd7, 5'd12, 5'd16, 5'd9, 5'd6};
        foreach (sizes[s]) begin
            drain_and_write(sizes[s]);
            lg = sizes[s];
            if (lg < MIN_REGION) lg = MIN_REGION;
            if (lg > 16) lg = 16;
            if (s == 2) long_stall = 1'b1;
            for (int i = 0; i < 140; i++)
                random_item(lg, (i / 35) % 2 == 1);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
